>>> rtl/csrms_pkg.sv
// Shared constants, codes and types for the compressed-sparse-row matrix store.
package csrms_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_ENTRIES = 1024;
  localparam int COLUMN_BITS = 8;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int ENT_AW = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = 11;  // entry_count field width
  localparam int RCNT_W = 9;   // rows_closed field width

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_ADD    = 3'd4,
    OP_FILL   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADROW = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RS_LO,
    S_RS_HI,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FILL,
    S_DONE
  } state_t;

  localparam logic [2:0] REG_ROW_COUNT = 3'd0;
  localparam logic [2:0] REG_CAPACITY  = 3'd4;

endpackage

>>> rtl/csr_sparse_matrix_store.sv
// Top level of the compressed-sparse-row matrix store with its sequencer.
//
// Usage: requests enter on the in_ stream (operation in in_tuser; row,
// column and Q16.16 value in in_tdata). Each request gives exactly one
// result on the out_ stream: value, found flag, entry and closed-row
// counts and a status code. Registers row_count and entry_capacity are
// written over the APB-style cfg_ port; the user must do so only while the
// block is idle, which the block does not enforce. Writing row_count
// restarts the build. Flow: one request at a time; a new request is
// accepted only once the previous result is in the output register.
// Read, write and add fetch the row bounds, then scan the entries of that
// row in order up to the first matching column (one shared column compare
// and one value adder, on the registered memory read port). Fill_all
// sweeps all MAX_ENTRIES value slots, one a cycle.
// Reset clears counters and registers (row_count 0, entry_capacity 1024);
// no memory clearing pass is needed. A stalled result holds in the output
// register; a later result waits in S_DONE until the stalled one is taken.
module csr_sparse_matrix_store
  import csrms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[7:0], column[15:8], value[47:16]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[31:0], found[32], entry_count[43:33], rows_closed[52:44],
  // status[54:53], zero pad[55]
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  state_t state_r, state_nxt;

  logic [RCNT_W-1:0] row_count_r;
  logic [CNT_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  ent_cnt_r, ent_cnt_nxt;
  logic [RCNT_W-1:0] row_cnt_r, row_cnt_nxt;

  logic [2:0]  op_r;
  logic [7:0]  row_r;
  logic [7:0]  col_r;
  logic [31:0] val_r;

  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;

  logic [31:0]   rv_r, rv_nxt;
  logic          fnd_r, fnd_nxt;
  status_t       st_r, st_nxt;

  logic        out_valid_r;
  logic [55:0] out_data_r;

  logic [RCNT_W-1:0] rows_use;
  logic [CNT_W-1:0]  cap_use;
  logic              cfg_wr;

  // Memory ports
  logic              rs_we;
  logic [ROW_AW-1:0] rs_waddr, rs_raddr;
  logic [CNT_W-1:0]  rs_rdata;
  logic              col_we;
  logic [COLUMN_BITS-1:0] col_rdata;
  logic              val_we;
  logic [ENT_AW-1:0] val_waddr;
  logic [31:0]       val_wdata, val_rdata;

  // Saturating adder shared by add requests
  logic [32:0] sum;
  logic [31:0] sum_sat;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign rows_use   = (row_count_r > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_count_r;
  assign cap_use    = (capacity_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity_r;

  assign sum     = {val_rdata[31], val_rdata} + {val_r[31], val_r};
  assign sum_sat = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : sum[31:0];

  // Register read-back
  always_comb begin
    unique case (cfg_paddr)
      REG_ROW_COUNT: cfg_prdata = {{(32-RCNT_W){1'b0}}, row_count_r};
      REG_CAPACITY:  cfg_prdata = {{(32-CNT_W){1'b0}}, capacity_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Row starts: entry k holds the start of row k+1; row 0 starts at zero
  csrms_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_row_start (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(ent_cnt_r),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  csrms_ram #(.WIDTH(COLUMN_BITS), .DEPTH(MAX_ENTRIES)) u_col_store (
    .clk(clk), .we(col_we), .waddr(ent_cnt_r[ENT_AW-1:0]),
    .wdata(col_r[COLUMN_BITS-1:0]), .raddr(ptr_r[ENT_AW-1:0]), .rdata(col_rdata)
  );

  csrms_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_val_store (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(ptr_r[ENT_AW-1:0]), .rdata(val_rdata)
  );

  // Fetch the row start first, then the next row start; row 0 needs only the end
  assign rs_waddr = row_cnt_r[ROW_AW-1:0];
  assign rs_raddr = (state_r == S_EXEC && row_r != '0) ? (row_r[ROW_AW-1:0] - ROW_AW'(1))
                                                       : row_r[ROW_AW-1:0];
  assign in_tready = (state_r == S_IDLE);

  // Sequencer: next state, counters and memory writes
  always_comb begin
    state_nxt   = state_r;
    ent_cnt_nxt = ent_cnt_r;
    row_cnt_nxt = row_cnt_r;
    hi_nxt      = hi_r;
    ptr_nxt     = ptr_r;
    rv_nxt      = rv_r;
    fnd_nxt     = fnd_r;
    st_nxt      = st_r;
    rs_we       = 1'b0;
    col_we      = 1'b0;
    val_we      = 1'b0;
    val_waddr   = ptr_r[ENT_AW-1:0];
    val_wdata   = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rv_nxt    = '0;
          fnd_nxt   = 1'b0;
          st_nxt    = ST_OK;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        priority case (op_r)
          OP_INSERT: begin
            if (row_cnt_r >= rows_use) begin
              st_nxt = ST_BADROW;
            end else if (ent_cnt_r >= cap_use) begin
              st_nxt = ST_FULL;
            end else begin
              col_we      = 1'b1;
              val_we      = 1'b1;
              val_waddr   = ent_cnt_r[ENT_AW-1:0];
              ent_cnt_nxt = ent_cnt_r + CNT_W'(1);
            end
          end
          OP_CLOSE: begin
            if (row_cnt_r >= rows_use) begin
              st_nxt = ST_BADROW;
            end else begin
              rs_we       = 1'b1;
              row_cnt_nxt = row_cnt_r + RCNT_W'(1);
            end
          end
          OP_READ, OP_WRITE, OP_ADD: begin
            if ({1'b0, row_r} >= rows_use || {1'b0, row_r} >= row_cnt_r) begin
              st_nxt = ST_BADROW;
            end else if (row_r == '0) begin
              ptr_nxt   = '0;
              state_nxt = S_RS_HI;
            end else begin
              state_nxt = S_RS_LO;
            end
          end
          OP_FILL: begin
            ptr_nxt   = '0;
            state_nxt = S_FILL;
          end
          default: ;
        endcase
      end
      S_RS_LO: begin
        ptr_nxt   = rs_rdata;
        state_nxt = S_RS_HI;
      end
      S_RS_HI: begin
        hi_nxt = rs_rdata;
        if (ptr_r >= rs_rdata) begin
          st_nxt    = ST_ABSENT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (col_rdata == col_r[COLUMN_BITS-1:0]) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_DONE;
          priority case (op_r)
            OP_WRITE: begin
              val_we = 1'b1;
              rv_nxt = val_r;
            end
            OP_ADD: begin
              val_we    = 1'b1;
              val_wdata = sum_sat;
              rv_nxt    = sum_sat;
            end
            default: rv_nxt = val_rdata;
          endcase
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
          if (ptr_nxt >= hi_r) begin
            st_nxt    = ST_ABSENT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_FILL: begin
        val_we  = 1'b1;
        ptr_nxt = ptr_r + CNT_W'(1);
        if (ptr_r == CNT_W'(MAX_ENTRIES - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // Restart the build on a row_count write
    if (cfg_wr && cfg_paddr == REG_ROW_COUNT) begin
      ent_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ent_cnt_r   <= '0;
      row_cnt_r   <= '0;
      row_count_r <= '0;
      capacity_r  <= CNT_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ent_cnt_r <= ent_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (cfg_wr && cfg_paddr == REG_ROW_COUNT) begin
        row_count_r <= cfg_pwdata[RCNT_W-1:0];
      end
      if (cfg_wr && cfg_paddr == REG_CAPACITY) begin
        capacity_r <= cfg_pwdata[CNT_W-1:0];
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and working payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      op_r  <= in_tuser;
      row_r <= in_tdata[7:0];
      col_r <= in_tdata[15:8];
      val_r <= in_tdata[47:16];
    end
    hi_r  <= hi_nxt;
    ptr_r <= ptr_nxt;
    rv_r  <= rv_nxt;
    fnd_r <= fnd_nxt;
    st_r  <= st_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {1'b0, st_r, row_cnt_r, ent_cnt_r, fnd_r, rv_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Counters never pass their limits
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ent_cnt_r <= CNT_W'(MAX_ENTRIES) && row_cnt_r <= RCNT_W'(MAX_ROWS))
    else $error("build counter out of range");

  // Counters move only when a request executes or the build restarts
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC && !cfg_wr) |=> ($stable(ent_cnt_r) && $stable(row_cnt_r)))
    else $error("counter changed outside execution");

  // A found entry always reports ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[32]) |-> (out_data_r[54:53] == ST_OK))
    else $error("found with error status");

  // Input is refused while a request is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid) |=> !in_tready)
    else $error("accepted a request while busy");

endmodule

>>> rtl/csrms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csrms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sim/tb_csr_sparse_matrix_store.sv
// Self-checking testbench for the compressed-sparse-row matrix store.
module tb_csr_sparse_matrix_store;
  import csrms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int         TARGET_REQUESTS = 1350;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] val;
  } request_t;

  // Packed from the top bit down: status highest, read_value lowest
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  rows_closed;
    logic [10:0] entry_count;
    logic        found;
    logic [31:0] read_value;
  } answer_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } cell_ref_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  csr_sparse_matrix_store dut (.*);

  always #10 clk = ~clk;

  // Predictor state
  int          m_row_count = 0;
  int          m_capacity = 1024;
  int          m_row_start [MAX_ROWS+1];
  logic [7:0]  m_cols [MAX_ENTRIES];
  logic [31:0] m_vals [MAX_ENTRIES];
  int          m_entries = 0;
  int          m_closed = 0;

  request_t    pending_q [$];
  answer_t     answer_q [$];
  request_t    on_bus;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold = 0;
  int          errors = 0;
  int          requests_made = 0;

  function automatic void restart_build();
    m_entries = 0;
    m_closed = 0;
    foreach (m_row_start[i]) m_row_start[i] = 0;
  endfunction

  // Compute the answer of one request and update the stored matrix
  function automatic answer_t store_request(request_t q);
    answer_t a;
    int rows_eff, cap_eff, hit, hi;
    logic signed [32:0] sum;
    a = '0;
    rows_eff = (m_row_count < MAX_ROWS) ? m_row_count : MAX_ROWS;
    cap_eff = (m_capacity < MAX_ENTRIES) ? m_capacity : MAX_ENTRIES;
    a.status = ST_OK;
    case (q.op)
      OP_INSERT: begin
        if (m_closed >= rows_eff) a.status = ST_BADROW;
        else if (m_entries >= cap_eff) a.status = ST_FULL;
        else begin
          m_cols[m_entries] = q.col;
          m_vals[m_entries] = q.val;
          m_entries++;
        end
      end
      OP_CLOSE: begin
        if (m_closed >= rows_eff) a.status = ST_BADROW;
        else begin
          m_row_start[m_closed+1] = m_entries;
          m_closed++;
        end
      end
      OP_READ, OP_WRITE, OP_ADD: begin
        if (q.row >= rows_eff || q.row >= m_closed) a.status = ST_BADROW;
        else begin
          hit = -1;
          hi = m_row_start[q.row+1];
          if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
          for (int i = m_row_start[q.row]; i < hi; i++)
            if (hit < 0 && m_cols[i] == q.col) hit = i;
          if (hit < 0) a.status = ST_ABSENT;
          else begin
            if (q.op == OP_WRITE) m_vals[hit] = q.val;
            else if (q.op == OP_ADD) begin
              sum = $signed({m_vals[hit][31], m_vals[hit]}) + $signed({q.val[31], q.val});
              if (sum > 33'sh07FFFFFFF) m_vals[hit] = 32'h7FFFFFFF;
              else if (sum < -33'sh080000000) m_vals[hit] = 32'h80000000;
              else m_vals[hit] = sum[31:0];
            end
            a.read_value = m_vals[hit];
            a.found = 1'b1;
          end
        end
      end
      OP_FILL: foreach (m_vals[i]) m_vals[i] = q.val;
      default: ;
    endcase
    a.entry_count = m_entries[10:0];
    a.rows_closed = m_closed[8:0];
    return a;
  endfunction

  // Driver: present pending requests, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) answer_q.push_back(store_request(on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {on_bus.val, on_bus.col, on_bus.row};
          in_tuser <= on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result with the oldest answer
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[54:0];
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, got.read_value);
            errors++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, got.entry_count);
            errors++;
          end
          if (got.rows_closed !== want.rows_closed) begin
            $display("%0t: rows_closed expected %0d actual %0d", $time,
                     want.rows_closed, got.rows_closed);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic drain();
    wait (pending_q.size() == 0 && answer_q.size() == 0 && !in_tvalid);
    repeat (8) @(posedge clk);
  endtask

  // Write a register with a setup and an access cycle
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_ROW_COUNT) begin
      m_row_count = data & 32'h1FF;
      restart_build();
    end else begin
      m_capacity = data & 32'h7FF;
    end
  endtask

  task automatic push(input logic [2:0] op, input logic [7:0] row, input logic [7:0] col,
                      input logic [31:0] val);
    request_t q;
    q.op = op;
    q.row = row;
    q.col = col;
    q.val = val;
    pending_q.push_back(q);
    requests_made++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Build a matrix row by row, then query and update it at random
  task automatic random_phase(input int rows, input int max_per_row, input int n_ops,
                              input bit leave_open);
    cell_ref_t cells [$];
    cell_ref_t c;
    int k, sel, nrow;
    logic [7:0] col;
    nrow = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    for (int r = 0; r < nrow; r++) begin
      k = $urandom_range(max_per_row);
      for (int j = 0; j < k; j++) begin
        col = 8'($urandom);
        if (cells.size() > 0 && cells[$].row == r && $urandom_range(4) == 0)
          col = cells[$].col;
        c.row = 8'(r);
        c.col = col;
        cells.push_back(c);
        push(OP_INSERT, 8'($urandom), col, pick_value());
      end
      if (!(leave_open && r == nrow - 1))
        push(OP_CLOSE, 8'($urandom), 8'($urandom), $urandom);
    end
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(99);
      if (cells.size() > 0 && $urandom_range(4) != 0) c = cells[$urandom_range(cells.size()-1)];
      else begin
        c.row = 8'($urandom_range(nrow + 2));
        c.col = 8'($urandom);
      end
      if (sel < 2) push(OP_FILL, 8'($urandom), 8'($urandom), pick_value());
      else if (sel < 36) push(OP_READ, c.row, c.col, $urandom);
      else if (sel < 62) push(OP_WRITE, c.row, c.col, pick_value());
      else if (sel < 92) push(OP_ADD, c.row, c.col, pick_value());
      else push(3'($urandom_range(7)), 8'($urandom), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    int phase, rows;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: three rows, four entry slots
    cfg_write(REG_CAPACITY, 32'd4);
    cfg_write(REG_ROW_COUNT, 32'd3);
    push(OP_READ, 8'd0, 8'd0, 32'd0);                // row not yet closed
    push(OP_INSERT, 8'd0, 8'hFF, 32'h7FFFFFFF);
    push(OP_INSERT, 8'd0, 8'h00, 32'h80000000);
    push(OP_INSERT, 8'd0, 8'hFF, 32'h00010000);      // duplicate column
    push(OP_CLOSE, 8'd0, 8'd0, 32'd0);
    push(OP_READ, 8'd0, 8'hFF, 32'd0);
    push(OP_ADD, 8'd0, 8'hFF, 32'h7FFFFFFF);         // saturate high
    push(OP_ADD, 8'd0, 8'h00, 32'h80000000);         // saturate low
    push(OP_WRITE, 8'd0, 8'h00, 32'hFFFFFFFF);
    push(OP_READ, 8'd0, 8'h5A, 32'd0);               // absent
    push(OP_INSERT, 8'd1, 8'h12, 32'h12345678);
    push(OP_INSERT, 8'd1, 8'h34, 32'd1);             // store full
    push(OP_CLOSE, 8'd1, 8'd0, 32'd0);
    push(OP_CLOSE, 8'd2, 8'd0, 32'd0);               // empty row
    push(OP_READ, 8'd2, 8'h12, 32'd0);
    push(OP_CLOSE, 8'd0, 8'd0, 32'd0);               // all rows closed
    push(OP_INSERT, 8'd0, 8'd1, 32'd1);
    push(OP_READ, 8'd3, 8'h12, 32'd0);               // row out of range
    push(OP_READ, 8'hFF, 8'hFF, 32'd0);
    push(OP_FILL, 8'hFF, 8'hFF, 32'hDEADBEEF);
    push(OP_READ, 8'd1, 8'h12, 32'd0);
    push(OP_SPARE6, 8'hFF, 8'hFF, 32'hFFFFFFFF);
    push(OP_SPARE7, 8'd0, 8'd0, 32'd0);
    drain();

    // Random phases across register settings and idling modes
    phase = 0;
    while (requests_made < TARGET_REQUESTS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (phase % 7)
        0: cfg_write(REG_CAPACITY, 32'd1024);
        1: cfg_write(REG_CAPACITY, 32'd0);
        2: cfg_write(REG_CAPACITY, 32'h7FF);
        3: cfg_write(REG_CAPACITY, $urandom_range(30, 1));
        default: cfg_write(REG_CAPACITY, $urandom_range(1024, 40));
      endcase
      case (phase % 9)
        0: rows = 0;
        1: rows = 256;
        2: rows = 511;
        default: rows = $urandom_range(12, 1);
      endcase
      cfg_write(REG_ROW_COUNT, rows);
      if (rows >= 256) random_phase(rows, 1, 40, 1'b0);
      else random_phase(rows, 6, 60, (phase % 5) == 3);
      if (phase == 2) recv_hold = 400;
      if (phase == 5) begin
        drain();
        random_phase(0, 0, 20, 1'b0);
      end
      drain();
      phase++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/csrms_pkg.sv
rtl/csrms_ram.sv
rtl/csr_sparse_matrix_store.sv
sim/tb_csr_sparse_matrix_store.sv
